FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the keyed list engine.
// Holds macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KSL_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ksl_pkg.sv
// Package for the keyed list engine: operation and status codes, key type.
// No dependencies.
package ksl_pkg;

    typedef logic signed [31:0] t_key;

    typedef enum logic [2:0] {
        KIND_APPEND       = 3'd0,
        KIND_FRONT        = 3'd1,
        KIND_SORTED       = 3'd2,
        KIND_REMOVE_LAST  = 3'd3,
        KIND_REMOVE_FIRST = 3'd4,
        KIND_REMOVE_KEY   = 3'd5,
        KIND_READ         = 3'd6,
        KIND_FIND_KEY     = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_NOKEY  = 3'd3,
        ST_BADPOS = 3'd4
    } t_status;

endpackage

FILE: hw/rtl/ksl_cell.sv
// One storage cell of the circulating entry chain: key plus payload.
// Depends on ksl_pkg.
module ksl_cell #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  ksl_pkg::t_key            i_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_payload,
    output ksl_pkg::t_key            o_key,
    output logic [PAYLOAD_WIDTH-1:0] o_payload
);
    import ksl_pkg::*;

    t_key                     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;

    // take the input entry on every shift cycle
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key     <= i_key;
            r_payload <= i_payload;
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

FILE: hw/rtl/keyed_sequential_list_engine_unit.sv
// Keyed list engine top level: control sequencer and the ring of entry cells.
// Depends on ksl_pkg, ksl_cell and assert_macros.svh.
//
// Fixed-capacity packed list of (signed key, payload) records. Entries live
// in a ring of CAPACITY ksl_cell instances that all shift by one place per
// cycle while a ring pass is running. A full pass of CAPACITY shifts
// streams every slot past the tail in list order (slot 0 first) and back
// into the head, so the list comes back in place. The sequencer edits the
// stream on the fly: an insert pushes the new record and then runs one
// slot late through a carry register, a remove skips one slot by taking
// the tail's neighbor instead of the tail, and key search, sorted-insert
// search and read by position compare the tail against the operand.
// Sequence: append, insert, remove first, remove by key, read by position
// and find go through accept, a full ring pass and a finish state, and no
// new transaction is accepted until the finish state is left; the pass
// length is set by the ring. Remove last, and every transaction rejected
// at accept (full, empty, bad position), skips the pass and goes straight to finish.
// One transaction is worked on at a time; in_ready is high only when idle.
// The result sits in an output register, so a new transaction can be
// accepted while the previous result still waits to be taken; the finish
// cycle repeats for as long as that earlier result is still held there.
// Stored payloads are PAYLOAD_WIDTH bits; the result payload is
// zero-extended.
module keyed_sequential_list_engine_unit #(
    parameter int CAPACITY      = 64,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_kind,
    input  ksl_pkg::t_key         i_record_key,
    input  logic [31:0]           i_record_payload,
    input  logic [6:0]            i_position,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_status,
    output ksl_pkg::t_key         o_found_key,
    output logic [31:0]           o_found_payload,
    output logic [6:0]            o_entry_count,
    output logic                  o_is_full,
    output logic                  o_is_empty
);
    import ksl_pkg::*;

`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);               // count width
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // pass index
    localparam int XW = (CW > 7) ? CW + 1 : 8;              // position compare
    localparam int PW = PAYLOAD_WIDTH;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_T = IW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state          r_state;
    logic [IW-1:0]   r_t;        // pass cycle = slot index at the tail
    logic [CW-1:0]   r_count;
    logic            r_done;     // edit point already passed
    t_kind           r_kind;
    t_key            r_key;
    logic [PW-1:0]   r_pay;
    logic [6:0]      r_pos;
    t_status         r_status;
    t_key            r_fkey;
    logic [PW-1:0]   r_fpay;
    t_key            r_carry_key;
    logic [PW-1:0]   r_carry_pay;

    logic            r_out_valid;
    t_status         r_out_status;
    t_key            r_out_fkey;
    logic [PW-1:0]   r_out_fpay;
    logic [CW-1:0]   r_out_count;

    // ring of cells
    t_key            w_cell_key [CAPACITY];
    logic [PW-1:0]   w_cell_pay [CAPACITY];
    t_key            w_push_key;
    logic [PW-1:0]   w_push_pay;
    t_key            w_tail_key;
    logic [PW-1:0]   w_tail_pay;
    t_key            w_next_key;
    logic [PW-1:0]   w_next_pay;
    logic            w_shift;

    assign w_shift = (r_state == S_SCAN);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_ring
        if (k == 0) begin : g_head
            ksl_cell #(.PAYLOAD_WIDTH(PW)) u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_shift),
                .i_key     (w_push_key),
                .i_payload (w_push_pay),
                .o_key     (w_cell_key[k]),
                .o_payload (w_cell_pay[k])
            );
        end else begin : g_body
            ksl_cell #(.PAYLOAD_WIDTH(PW)) u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_shift),
                .i_key     (w_cell_key[k-1]),
                .i_payload (w_cell_pay[k-1]),
                .o_key     (w_cell_key[k]),
                .o_payload (w_cell_pay[k])
            );
        end
    end

    assign w_tail_key = w_cell_key[CAPACITY-1];
    assign w_tail_pay = w_cell_pay[CAPACITY-1];

    // tail's neighbor holds the following slot; used to close a gap
    if (CAPACITY > 1) begin : g_look
        assign w_next_key = w_cell_key[CAPACITY-2];
        assign w_next_pay = w_cell_pay[CAPACITY-2];
    end else begin : g_nolook
        assign w_next_key = '0;
        assign w_next_pay = '0;
    end

    // pass decisions
    logic w_in_range;
    logic w_cond;
    logic w_hit;
    logic w_is_insert;
    logic w_is_remove;
    logic w_is_capture;

    assign w_in_range = (CW'(r_t) < r_count);
    assign w_is_insert = (r_kind == KIND_APPEND) || (r_kind == KIND_FRONT)
                      || (r_kind == KIND_SORTED);
    assign w_is_remove = (r_kind == KIND_REMOVE_FIRST) || (r_kind == KIND_REMOVE_KEY);
    assign w_is_capture = (r_kind == KIND_READ) || (r_kind == KIND_FIND_KEY);

    always_comb begin
        unique case (r_kind)
            KIND_APPEND:       w_cond = (CW'(r_t) == r_count);
            KIND_FRONT,
            KIND_REMOVE_FIRST: w_cond = (r_t == '0);
            KIND_SORTED:       w_cond = !w_in_range || !(w_tail_key < r_key);
            KIND_REMOVE_KEY,
            KIND_FIND_KEY:     w_cond = w_in_range && (w_tail_key == r_key);
            KIND_READ:         w_cond = ((XW'(r_t) + XW'(1)) == XW'(r_pos));
            KIND_REMOVE_LAST:  w_cond = 1'b0;
            default:           w_cond = 1'b0;
        endcase
    end

    assign w_hit = !r_done && w_cond;

    always_comb begin
        w_push_key = w_tail_key;
        w_push_pay = w_tail_pay;
        if (w_is_insert) begin
            if (w_hit) begin
                w_push_key = r_key;
                w_push_pay = r_pay;
            end else if (r_done) begin
                w_push_key = r_carry_key;
                w_push_pay = r_carry_pay;
            end
        end else if (w_is_remove && (w_hit || r_done)) begin
            w_push_key = w_next_key;
            w_push_pay = w_next_pay;
        end
    end

    // checks done at accept, before any pass
    t_kind   w_in_kind;
    logic    w_early;
    t_status w_early_status;
    logic    w_in_insert;
    logic    w_in_needs_entry;

    assign w_in_kind = t_kind'(i_kind);
    assign w_in_insert = (w_in_kind == KIND_APPEND) || (w_in_kind == KIND_FRONT)
                      || (w_in_kind == KIND_SORTED);
    assign w_in_needs_entry = (w_in_kind == KIND_REMOVE_LAST)
                           || (w_in_kind == KIND_REMOVE_FIRST)
                           || (w_in_kind == KIND_REMOVE_KEY)
                           || (w_in_kind == KIND_FIND_KEY);

    always_comb begin
        w_early        = 1'b0;
        w_early_status = ST_OK;
        priority if (w_in_insert && (r_count == CAP_C)) begin
            w_early        = 1'b1;
            w_early_status = ST_FULL;
        end else if (w_in_needs_entry && (r_count == '0)) begin
            w_early        = 1'b1;
            w_early_status = ST_EMPTY;
        end else if (w_in_kind == KIND_REMOVE_LAST) begin
            w_early        = 1'b1;
        end else if ((w_in_kind == KIND_READ)
                  && ((i_position == '0) || (XW'(i_position) > XW'(r_count)))) begin
            w_early        = 1'b1;
            w_early_status = ST_BADPOS;
        end else begin
            w_early        = 1'b0;
        end
    end

    logic w_done_end;
    assign w_done_end = r_done || w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_t         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the finish state sets valid itself
            if (i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind   <= w_in_kind;
                        r_key    <= i_record_key;
                        r_pay    <= PW'(i_record_payload);
                        r_pos    <= i_position;
                        r_fkey   <= '0;
                        r_fpay   <= '0;
                        r_done   <= 1'b0;
                        r_t      <= '0;
                        r_status <= w_early_status;
                        if (w_early) begin
                            if ((w_in_kind == KIND_REMOVE_LAST)
                                    && (w_early_status == ST_OK)) begin
                                r_count <= r_count - CW'(1);
                            end
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_t         <= r_t + IW'(1);
                    r_carry_key <= w_tail_key;
                    r_carry_pay <= w_tail_pay;
                    if (w_hit) begin
                        r_done <= 1'b1;
                        if (w_is_capture) begin
                            r_fkey <= w_tail_key;
                            r_fpay <= w_tail_pay;
                        end
                    end
                    if (r_t == LAST_T) begin
                        r_state <= S_FINISH;
                        if (w_is_insert) begin
                            r_count <= r_count + CW'(1);
                        end else if (w_is_remove) begin
                            if (w_done_end) begin
                                r_count <= r_count - CW'(1);
                            end else begin
                                r_status <= ST_NOKEY;
                            end
                        end else if ((r_kind == KIND_FIND_KEY) && !w_done_end) begin
                            r_status <= ST_NOKEY;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_fkey   <= r_fkey;
                        r_out_fpay   <= r_fpay;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found_key     = r_out_fkey;
    assign o_found_payload = 32'(r_out_fpay);
    assign o_entry_count   = 7'(r_out_count);
    assign o_is_full       = (r_out_count == CAP_C);
    assign o_is_empty      = (r_out_count == '0);

    // occupancy never runs past the ring
    `KSL_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_C,
        "entry count above capacity")
    // an accepted transaction closes the request side until it finishes
    `KSL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "request accepted while busy")
    // a pass always runs to its last slot before finishing
    `KSL_ASSERT_NEXT(a_pass_length, i_clk, i_rst_n,
        (r_state == S_SCAN) && (r_t != LAST_T), r_state == S_SCAN,
        "ring pass ended early")
    // a result never claims full and empty at once
    `KSL_ASSERT(a_full_empty, i_clk, i_rst_n, o_out_valid, !(o_is_full && o_is_empty),
        "full and empty together")

endmodule

FILE: tb/keyed_sequential_list_engine_unit_tb.sv
// Self-checking testbench for keyed_sequential_list_engine_unit.
// Holds a shadow copy of the record list and drives both valid/ready channels.
// Depends on ksl_pkg and the RTL of the keyed list engine.
module keyed_sequential_list_engine_unit_tb;
    import ksl_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int PAYLOAD_WIDTH  = 32;
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT   = 10;

    localparam t_key KEY_MAX = 32'sh7fff_ffff;
    localparam t_key KEY_MIN = t_key'(32'h8000_0000);

    // One result transaction as the block returns it.
    typedef struct {
        t_status     status;
        t_key        key;
        logic [31:0] payload;
        logic [6:0]  count;
        logic        full;
        logic        empty;
    } t_list_reply;

    // Stimulus mix: grow the list to full, shrink it to empty, then plain noise.
    typedef enum {FILL_UP, DRAIN_DOWN, MIXED} t_mix;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_kind           = '0;
    t_key        i_record_key     = '0;
    logic [31:0] i_record_payload = '0;
    logic [6:0]  i_position       = '0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic [2:0]  o_status;
    t_key        o_found_key;
    logic [31:0] o_found_payload;
    logic [6:0]  o_entry_count;
    logic        o_is_full;
    logic        o_is_empty;

    // Set by the stimulus side only; the result side just reads them.
    logic steady      = 1'b0;   // no idling on either side while high
    logic stall_armed = 1'b0;   // asks the result side for one long hold-off

    // Shadow list plus the queue of results still owed by the block.
    class t_record_list_tracker;
        t_key        keys[CAPACITY];
        logic [31:0] payloads[CAPACITY];
        int          held;
        t_list_reply pending_replies[$];
        int          faults;

        function new();
            held   = 0;
            faults = 0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Packs the list down over slot 'at'; the caller drops the count.
        function void close_gap(int at);
            int k;
            for (k = at; k + 1 < held; k++) begin
                keys[k]     = keys[k + 1];
                payloads[k] = payloads[k + 1];
            end
        endfunction

        // Applies one request to the shadow list and returns the result it owes.
        function t_list_reply apply_request(t_kind kind, t_key key, logic [31:0] payload,
                                            logic [6:0] position);
            t_list_reply reply;
            int          slot;
            int          k;
            reply.status  = ST_OK;
            reply.key     = '0;
            reply.payload = '0;
            case (kind)
                KIND_APPEND, KIND_FRONT, KIND_SORTED: begin
                    if (held >= CAPACITY) begin
                        reply.status = ST_FULL;
                    end else begin
                        slot = (kind == KIND_APPEND) ? held : 0;
                        // sorted insert lands ahead of the first key >= the new one
                        if (kind == KIND_SORTED) begin
                            while (slot < held && keys[slot] < key) slot++;
                        end
                        for (k = held; k > slot; k--) begin
                            keys[k]     = keys[k - 1];
                            payloads[k] = payloads[k - 1];
                        end
                        keys[slot]     = key;
                        payloads[slot] = payload;
                        held++;
                    end
                end
                KIND_REMOVE_LAST, KIND_REMOVE_FIRST: begin
                    if (held == 0) begin
                        reply.status = ST_EMPTY;
                    end else begin
                        if (kind == KIND_REMOVE_FIRST) close_gap(0);
                        held--;
                    end
                end
                KIND_REMOVE_KEY, KIND_FIND_KEY: begin
                    if (held == 0) begin
                        reply.status = ST_EMPTY;
                    end else begin
                        slot = 0;
                        while (slot < held && keys[slot] != key) slot++;
                        if (slot >= held) begin
                            reply.status = ST_NOKEY;
                        end else if (kind == KIND_REMOVE_KEY) begin
                            close_gap(slot);
                            held--;
                        end else begin
                            reply.key     = keys[slot];
                            reply.payload = payloads[slot];
                        end
                    end
                end
                default: begin
                    if (position == 0 || position > held) begin
                        reply.status = ST_BADPOS;
                    end else begin
                        reply.key     = keys[position - 1];
                        reply.payload = payloads[position - 1];
                    end
                end
            endcase
            reply.count = held[6:0];
            reply.full  = (held == CAPACITY);
            reply.empty = (held == 0);
            return reply;
        endfunction

        function void note_request(t_kind kind, t_key key, logic [31:0] payload,
                                   logic [6:0] position);
            pending_replies.push_back(apply_request(kind, key, payload, position));
        endfunction

        function void report_field(string field, logic [31:0] want, logic [31:0] got);
            faults++;
            if (faults <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_reply(logic [2:0] status, t_key key, logic [31:0] payload,
                                  logic [6:0] count, logic full, logic empty);
            t_list_reply want;
            if (pending_replies.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("result with nothing outstanding: status %0d count %0d",
                             status, count);
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status)
                report_field("status", 32'(want.status), 32'(status));
            if (key !== want.key)
                report_field("found_key", want.key, key);
            if (payload !== want.payload)
                report_field("found_payload", want.payload, payload);
            if (count !== want.count)
                report_field("entry_count", 32'(want.count), 32'(count));
            if (full !== want.full)
                report_field("is_full", 32'(want.full), 32'(full));
            if (empty !== want.empty)
                report_field("is_empty", 32'(want.empty), 32'(empty));
        endfunction
    endclass

    t_record_list_tracker tracker;

    keyed_sequential_list_engine_unit #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit: far above the slowest legal run.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Transaction monitor. Everything read here is the pre-edge value, since
    // all stimulus and all RTL state move by nonblocking assignment.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.note_request(t_kind'(i_kind), i_record_key, i_record_payload,
                                     i_position);
            if (o_out_valid && i_out_ready)
                tracker.check_reply(o_status, o_found_key, o_found_payload,
                                    o_entry_count, o_is_full, o_is_empty);
        end
    end

    // Offers one request and holds it until the block takes it. Returns at the
    // edge of acceptance, so a back-to-back caller keeps valid high untouched.
    task automatic send_request(t_kind kind, t_key key, logic [31:0] payload,
                                logic [6:0] position);
        while (!steady && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_record_key     <= key;
        i_record_payload <= payload;
        i_position       <= position;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Result side: random back-pressure, plus one long hold-off so the engine
    // ends up with a result parked, another in work, and its input stalled.
    initial begin : result_sink
        int  held_off;
        bit  stall_done;
        stall_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_armed && !stall_done) begin
                stall_done = 1'b1;
                i_out_ready <= 1'b0;
                for (held_off = 0; held_off < HOLD_OFF_CYCLES; held_off++)
                    @(posedge i_clk);
            end
            i_out_ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    initial begin : stimulus
        t_mix        mix;
        t_kind       kind;
        t_key        key;
        logic [6:0]  position;
        int          pick;
        int          linger;
        int          mixed_left;
        int          n;

        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every removal, search and read on an empty list first.
        send_request(KIND_REMOVE_LAST,  $urandom, $urandom, 7'd0);
        send_request(KIND_REMOVE_FIRST, $urandom, $urandom, 7'd1);
        send_request(KIND_REMOVE_KEY,   32'sd0, $urandom, 7'd0);
        send_request(KIND_FIND_KEY,     32'sd0, $urandom, 7'd0);
        send_request(KIND_READ,         $urandom, $urandom, 7'd1);
        // Key extremes and equal keys through the sorted insert.
        send_request(KIND_APPEND, KEY_MAX, 32'hffff_ffff, 7'd0);
        send_request(KIND_FRONT,  KEY_MIN, 32'h0000_0000, 7'd0);
        send_request(KIND_SORTED, 32'sd0,  32'ha5a5_a5a5, 7'd0);
        send_request(KIND_SORTED, 32'sd0,  32'h5a5a_5a5a, 7'd0);
        send_request(KIND_SORTED, KEY_MAX, 32'h1234_5678, 7'd0);
        // Reads at the edges of the held range, and past it.
        send_request(KIND_READ, $urandom, $urandom, 7'd0);
        send_request(KIND_READ, $urandom, $urandom, 7'd1);
        send_request(KIND_READ, $urandom, $urandom, 7'd5);
        send_request(KIND_READ, $urandom, $urandom, 7'd6);
        send_request(KIND_READ, $urandom, $urandom, 7'd127);
        // Duplicate keys resolve to the lowest position; absent keys leave the list.
        send_request(KIND_FIND_KEY,   32'sd0,     $urandom, 7'd0);
        send_request(KIND_FIND_KEY,   32'sd12345, $urandom, 7'd0);
        send_request(KIND_REMOVE_KEY, 32'sd12345, $urandom, 7'd0);
        send_request(KIND_REMOVE_KEY, 32'sd0,     $urandom, 7'd0);
        send_request(KIND_REMOVE_FIRST, $urandom, $urandom, 7'd0);
        send_request(KIND_REMOVE_LAST,  $urandom, $urandom, 7'd0);
        send_request(KIND_FIND_KEY,   KEY_MAX,    $urandom, 7'd0);

        // Random: alternate growing to full (and pushing on it) with draining
        // to empty (and popping on it), with short stretches of pure noise.
        mix        = FILL_UP;
        linger     = 0;
        mixed_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60) stall_armed <= 1'b1;
            steady <= (n >= 200 && n < 260);

            case (mix)
                FILL_UP: begin
                    if (tracker.held == CAPACITY) linger++;
                    if (linger >= 6) begin
                        mix    = DRAIN_DOWN;
                        linger = 0;
                    end
                end
                DRAIN_DOWN: begin
                    if (tracker.held == 0) linger++;
                    if (linger >= 5) begin
                        mix        = MIXED;
                        linger     = 0;
                        mixed_left = 40;
                    end
                end
                default: begin
                    mixed_left--;
                    if (mixed_left <= 0) mix = FILL_UP;
                end
            endcase

            pick = $urandom_range(99);
            case (mix)
                FILL_UP: begin
                    if (pick < 30)      kind = KIND_APPEND;
                    else if (pick < 50) kind = KIND_FRONT;
                    else if (pick < 75) kind = KIND_SORTED;
                    else if (pick < 80) kind = KIND_REMOVE_LAST;
                    else if (pick < 84) kind = KIND_REMOVE_FIRST;
                    else if (pick < 88) kind = KIND_REMOVE_KEY;
                    else if (pick < 94) kind = KIND_READ;
                    else                kind = KIND_FIND_KEY;
                end
                DRAIN_DOWN: begin
                    if (pick < 7)       kind = KIND_APPEND;
                    else if (pick < 14) kind = KIND_FRONT;
                    else if (pick < 20) kind = KIND_SORTED;
                    else if (pick < 40) kind = KIND_REMOVE_LAST;
                    else if (pick < 60) kind = KIND_REMOVE_FIRST;
                    else if (pick < 85) kind = KIND_REMOVE_KEY;
                    else if (pick < 93) kind = KIND_READ;
                    else                kind = KIND_FIND_KEY;
                end
                default: kind = t_kind'($urandom_range(7));
            endcase

            // Keys mostly from a narrow band so duplicates and hits are common;
            // the rest are extremes or fully random to move every bit.
            pick = $urandom_range(99);
            if (pick < 65) begin
                key = $urandom_range(16) - 8;
            end else if (pick < 80) begin
                case ($urandom_range(3))
                    0:       key = KEY_MIN;
                    1:       key = KEY_MAX;
                    2:       key = -1;
                    default: key = 0;
                endcase
            end else begin
                key = $urandom;
            end
            if ((kind == KIND_REMOVE_KEY || kind == KIND_FIND_KEY) && tracker.held > 0
                    && $urandom_range(1) == 1)
                key = tracker.keys[$urandom_range(tracker.held - 1)];

            if (tracker.held > 0 && $urandom_range(99) < 70)
                position = 7'($urandom_range(tracker.held, 1));
            else
                position = 7'($urandom_range(127));

            send_request(kind, key, $urandom, position);
        end
        i_in_valid <= 1'b0;
        steady     <= 1'b0;

        // Drain: let the monitor log the last request, wait for every
        // outstanding result, then stay quiet for longer than a full ring pass.
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        if (tracker.faults == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
